// File: src/lfbs_pkg.sv
// ----------------------------------------------------------------------------
// lfbs_pkg
// Shared codes, state type and word formatting for the LED framebuffer
// serializer.
// ----------------------------------------------------------------------------
package lfbs_pkg;

    localparam int unsigned PANEL_COLS_USED = 12;

    localparam logic [2:0] ACT_SET        = 3'd0;
    localparam logic [2:0] ACT_GET        = 3'd1;
    localparam logic [2:0] ACT_FILL       = 3'd2;
    localparam logic [2:0] ACT_FLUSH      = 3'd3;
    localparam logic [2:0] ACT_BRIGHTNESS = 3'd4;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_PIXEL = 2'd1;
    localparam logic [1:0] KIND_LINK  = 2'd2;

    localparam logic [15:0] WRITE_HEADER   = 16'h2800;
    localparam logic [15:0] COMMAND_HEADER = 16'h0400;
    localparam logic [15:0] PWM_COMMAND    = 16'h00A0;
    localparam logic [7:0]  MAX_LEVEL      = 8'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH
    } t_state;

    // control group from the sequencer to the pixel store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic fill_en;
        logic fill_value;
    } t_store_ctrl;

    function automatic logic [15:0] write_word(input logic [6:0] addr,
                                               input logic [3:0] nibble);
        logic [15:0] w;
        w = WRITE_HEADER | {5'd0, addr, 4'd0} | {12'd0, nibble};
        return w << 2;
    endfunction

    function automatic logic [15:0] brightness_word(input logic [7:0] level);
        logic [3:0]  lvl;
        logic [15:0] w;
        lvl = (level > MAX_LEVEL) ? MAX_LEVEL[3:0] : level[3:0];
        w = COMMAND_HEADER | PWM_COMMAND | {12'd0, lvl};
        return w << 5;
    endfunction

endpackage

// File: src/lfbs_in_if.sv
// ----------------------------------------------------------------------------
// lfbs_in_if
// Request channel: valid/ready plus one framebuffer command.
// ----------------------------------------------------------------------------
interface lfbs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       pixel_on;
    logic [7:0] brightness_level;

    modport source (output valid, action, pos_x, pos_y, pixel_on, brightness_level,
                    input ready);
    modport sink   (input valid, action, pos_x, pos_y, pixel_on, brightness_level,
                    output ready);
endinterface

// File: src/lfbs_out_if.sv
// ----------------------------------------------------------------------------
// lfbs_out_if
// Result channel: valid/ready plus one result transaction.
// ----------------------------------------------------------------------------
interface lfbs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic        pixel_value;
    logic [15:0] link_word;
    logic        last;

    modport source (output valid, result_kind, pixel_value, link_word, last,
                    input ready);
    modport sink   (input valid, result_kind, pixel_value, link_word, last,
                    output ready);
endinterface

// File: src/lfbs_store.sv
// ----------------------------------------------------------------------------
// lfbs_store
// Framebuffer byte memory, registered read. Per-entry valid bits
// plus a fill byte let reset and fill take effect without a clearing pass.
// ----------------------------------------------------------------------------
module lfbs_store #(
    parameter int unsigned DEPTH = 24,
    parameter int unsigned AW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lfbs_pkg::t_store_ctrl i_ctrl,
    input  logic [AW-1:0]        i_rd_addr,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [7:0]           i_wr_data,
    output logic [7:0]           o_rd_data
);
    import lfbs_pkg::*;

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic             r_fill;
    logic [7:0]       r_rd_data;
    logic             r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fill     <= 1'b0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctrl.fill_en) begin
                r_valid <= '0;
                r_fill  <= i_ctrl.fill_value;
            end else if (i_ctrl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctrl.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten entries read as the last fill value (zero after reset)
    assign o_rd_data = r_rd_valid ? r_rd_data : {8{r_fill}};

endmodule

// File: src/led_matrix_framebuffer_serializer.sv
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_serializer
// One-bit LED framebuffer with pixel access and controller word serializer.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command per transaction (set, get, fill, flush,
//   brightness); o_out returns the results, the final one of each command
//   flagged by last.
//   Set, get, fill, brightness and unused codes: one result, loaded into the
//   output register from the execute state once that register is free; the
//   registered read of the byte memory is followed by its write-back there,
//   and no new command is taken before the sequencer is idle again.
//   Flush: 4*PANEL_ROWS link words, one per cycle while the receiver takes
//   them; the next byte is read while the current word is loaded.
//   A new command is accepted once the sequencer is idle, even while the
//   last result still sits in the output register.
//   Reset: synchronous; the framebuffer reads as all zeros right after,
//   with no clearing pass. Fill likewise needs no clearing pass.
//   Receiver stall: the output register holds its transaction and the
//   sequencer waits with it; nothing is dropped.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_serializer #(
    parameter int unsigned PANEL_ROWS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfbs_in_if.sink   i_in,
    lfbs_out_if.source o_out
);
    import lfbs_pkg::*;

    localparam int unsigned DEPTH  = 2 * PANEL_ROWS;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned NWORDS = 4 * PANEL_ROWS;
    localparam int unsigned WW     = $clog2(NWORDS);

    t_state          r_state, n_state;
    logic [2:0]      r_action;
    logic [AW-1:0]   r_addr;
    logic [2:0]      r_bitpos;
    logic            r_hit;
    logic            r_on;
    logic [7:0]      r_level;
    logic [WW-1:0]   r_widx, n_widx;

    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_kind, n_kind;
    logic            r_pix, n_pix;
    logic [15:0]     r_word, n_word;
    logic            r_last, n_last;

    t_store_ctrl     s_ctrl;
    logic [AW-1:0]   s_rd_addr;
    logic [7:0]      s_wr_data;
    logic [7:0]      s_rd_byte;
    logic            s_accept;
    logic            s_out_free;
    logic            s_hit_in;
    logic [AW-1:0]   s_addr_in;
    logic            s_last_word;
    logic [WW-1:0]   s_widx_inc;
    logic [3:0]      s_nibble;

    lfbs_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (s_ctrl),
        .i_rd_addr (s_rd_addr),
        .i_wr_addr (r_addr),
        .i_wr_data (s_wr_data),
        .o_rd_data (s_rd_byte)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign s_accept    = i_in.valid && i_in.ready;
    assign s_out_free  = !r_ovalid || o_out.ready;
    assign s_hit_in    = (i_in.pos_x < 8'(PANEL_COLS_USED)) &&
                         (i_in.pos_y < 8'(PANEL_ROWS));
    // byte index = (y*16 + x) >> 3 = 2y + x[3]
    assign s_addr_in   = AW'({i_in.pos_y, i_in.pos_x[3]});
    assign s_last_word = (r_widx == WW'(NWORDS - 1));
    assign s_widx_inc  = r_widx + 1'b1;
    assign s_nibble    = r_widx[0] ? s_rd_byte[7:4] : s_rd_byte[3:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = (i_in.action == ACT_FLUSH) ? ST_FLUSH : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (s_out_free) n_state = ST_IDLE;
            end
            ST_FLUSH: begin
                if (s_out_free && s_last_word) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs, memory control and datapath
    always_comb begin
        s_ctrl     = '0;
        s_rd_addr  = s_addr_in;
        s_wr_data  = s_rd_byte;
        s_wr_data[r_bitpos] = r_on;
        n_widx     = r_widx;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_kind     = r_kind;
        n_pix      = r_pix;
        n_word     = r_word;
        n_last     = r_last;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    s_ctrl.rd_en = 1'b1;
                    n_widx       = '0;
                    if (i_in.action == ACT_FLUSH) s_rd_addr = '0;
                end
            end
            ST_EXEC: begin
                if (s_out_free) begin
                    n_ovalid = 1'b1;
                    n_kind   = KIND_ACK;
                    n_pix    = 1'b0;
                    n_word   = '0;
                    n_last   = 1'b1;
                    case (r_action)
                        ACT_SET: s_ctrl.wr_en = r_hit;
                        ACT_GET: begin
                            n_kind = KIND_PIXEL;
                            n_pix  = r_hit && s_rd_byte[r_bitpos];
                        end
                        ACT_FILL: begin
                            s_ctrl.fill_en    = 1'b1;
                            s_ctrl.fill_value = r_on;
                        end
                        ACT_BRIGHTNESS: begin
                            n_kind = KIND_LINK;
                            n_word = brightness_word(r_level);
                        end
                        default: ;
                    endcase
                end
            end
            ST_FLUSH: begin
                if (s_out_free) begin
                    n_ovalid = 1'b1;
                    n_kind   = KIND_LINK;
                    n_pix    = 1'b0;
                    n_word   = write_word(7'(r_widx), s_nibble);
                    n_last   = s_last_word;
                    n_widx   = s_widx_inc;
                    // fetch the byte for the next word; harmless re-read mid-byte
                    s_ctrl.rd_en = !s_last_word;
                    s_rd_addr    = AW'(s_widx_inc[WW-1:1]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_action <= i_in.action;
            r_addr   <= s_addr_in;
            r_bitpos <= i_in.pos_x[2:0] ^ 3'd3;
            r_hit    <= s_hit_in;
            r_on     <= i_in.pixel_on;
            r_level  <= i_in.brightness_level;
        end
        r_widx <= n_widx;
        r_kind <= n_kind;
        r_pix  <= n_pix;
        r_word <= n_word;
        r_last <= n_last;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.result_kind = r_kind;
    assign o_out.pixel_value = r_pix;
    assign o_out.link_word   = r_word;
    assign o_out.last        = r_last;

endmodule

// File: src/lfbs_checker.sv
// ----------------------------------------------------------------------------
// lfbs_checker
// Port-level checks on the result channel of the framebuffer serializer.
// ----------------------------------------------------------------------------
module lfbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_kind,
    input logic        i_pix,
    input logic [15:0] i_word,
    input logic        i_last
);
    import lfbs_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable({i_kind, i_pix, i_word, i_last}))
        else $error("stalled result transaction changed");

    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_LINK |-> i_word == 16'd0)
        else $error("link word set on non-link result");

    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_PIXEL |-> !i_pix)
        else $error("pixel value set on non-pixel result");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind != KIND_LINK |-> i_last)
        else $error("single-result command without last");

endmodule

bind led_matrix_framebuffer_serializer lfbs_checker u_lfbs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.result_kind),
    .i_pix   (o_out.pixel_value),
    .i_word  (o_out.link_word),
    .i_last  (o_out.last)
);

// File: tb/led_matrix_framebuffer_serializer_test.sv
// ----------------------------------------------------------------------------
// led_matrix_framebuffer_serializer_test
// Drives pixel, fill, flush, brightness and spare commands into the LED
// framebuffer serializer under random idling on both channels. A shadow
// framebuffer predicts every result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module led_matrix_framebuffer_serializer_test;
    import lfbs_pkg::*;

    localparam int unsigned ROWS        = 12;
    localparam int unsigned STORE_BYTES = ROWS * 2;
    localparam int unsigned RANDOM_CMDS = 84;
    localparam int unsigned DRAIN_WAIT  = 16;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [1:0]  kind;
        logic        pixel;
        logic [15:0] word;
        logic        last;
    } t_link_result;

    logic i_clk;
    logic i_rst_n;

    lfbs_in_if  in_ch();
    lfbs_out_if out_ch();

    led_matrix_framebuffer_serializer #(
        .PANEL_ROWS(ROWS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    logic [7:0]   frame_bytes[STORE_BYTES];
    t_link_result expected_results[$];
    int           mismatch_count  = 0;
    bit           idling_on       = 1'b1;
    int           hold_off_cycles = 0;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // shadow framebuffer
    // ------------------------------------------------------------------
    function automatic bit pixel_slot(input logic [7:0] x, input logic [7:0] y,
                                      output int byte_idx, output int bit_pos);
        int idx;
        byte_idx = 0;
        bit_pos  = 0;
        if (x >= PANEL_COLS_USED || y >= ROWS)
            return 1'b0;
        idx      = int'(y) * 16 + int'(x);
        byte_idx = idx >> 3;
        // bit order runs backwards inside each nibble
        bit_pos  = (idx & 7) ^ 3;
        return 1'b1;
    endfunction

    function automatic t_link_result make_result(input logic [1:0] kind, input logic pix,
                                                 input logic [15:0] word, input logic last);
        t_link_result r;
        r.kind  = kind;
        r.pixel = pix;
        r.word  = word;
        r.last  = last;
        return r;
    endfunction

    task automatic predict_command(input logic [2:0] act, input logic [7:0] x,
                                   input logic [7:0] y, input logic on,
                                   input logic [7:0] level);
        int          bi;
        int          bp;
        logic        pix;
        logic [7:0]  cur;
        logic [3:0]  nib;
        logic [3:0]  lvl;
        logic [31:0] w;
        int          addr;
        case (act)
            ACT_SET: begin
                if (pixel_slot(x, y, bi, bp))
                    frame_bytes[bi][bp] = on;
                expected_results.push_back(make_result(KIND_ACK, 1'b0, 16'h0, 1'b1));
            end
            ACT_GET: begin
                pix = 1'b0;
                if (pixel_slot(x, y, bi, bp))
                    pix = frame_bytes[bi][bp];
                expected_results.push_back(make_result(KIND_PIXEL, pix, 16'h0, 1'b1));
            end
            ACT_FILL: begin
                for (int i = 0; i < STORE_BYTES; i++)
                    frame_bytes[i] = on ? 8'hFF : 8'h00;
                expected_results.push_back(make_result(KIND_ACK, 1'b0, 16'h0, 1'b1));
            end
            ACT_FLUSH: begin
                for (int r = 0; r < ROWS; r++) begin
                    for (int j = 0; j < 4; j++) begin
                        cur  = frame_bytes[2 * r + j / 2];
                        nib  = (j % 2) ? cur[7:4] : cur[3:0];
                        addr = 4 * r + j;
                        w    = (32'h2800 | ((32'(addr) & 32'h7F) << 4) | 32'(nib)) << 2;
                        expected_results.push_back(make_result(KIND_LINK, 1'b0, w[15:0],
                            (r == ROWS - 1) && (j == 3)));
                    end
                end
            end
            ACT_BRIGHTNESS: begin
                lvl = (level > 8'd15) ? 4'd15 : level[3:0];
                w   = (32'h0400 | 32'h00A0 | 32'(lvl)) << 5;
                expected_results.push_back(make_result(KIND_LINK, 1'b0, w[15:0], 1'b1));
            end
            default: begin
                expected_results.push_back(make_result(KIND_ACK, 1'b0, 16'h0, 1'b1));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!idling_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_command(input logic [2:0] act, input logic [7:0] x,
                                input logic [7:0] y, input logic on,
                                input logic [7:0] level);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid            = 1'b1;
        in_ch.action           = act;
        in_ch.pos_x            = x;
        in_ch.pos_y            = y;
        in_ch.pixel_on         = on;
        in_ch.brightness_level = level;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        predict_command(act, x, y, on, level);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int r;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                out_ch.ready    = 1'b0;
                hold_off_cycles = hold_off_cycles - 1;
            end else if (!idling_on) begin
                out_ch.ready = 1'b1;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left   = stall_left - 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    out_ch.ready = 1'b1;
                end else begin
                    out_ch.ready = 1'b0;
                    stall_left   = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_link_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, link_word", 0, 32'(out_ch.link_word));
            end else begin
                want = expected_results.pop_front();
                if (out_ch.result_kind !== want.kind)
                    report_mismatch("result_kind", 32'(want.kind), 32'(out_ch.result_kind));
                if (out_ch.pixel_value !== want.pixel)
                    report_mismatch("pixel_value", 32'(want.pixel), 32'(out_ch.pixel_value));
                if (out_ch.link_word !== want.word)
                    report_mismatch("link_word", 32'(want.word), 32'(out_ch.link_word));
                if (out_ch.last !== want.last)
                    report_mismatch("last", 32'(want.last), 32'(out_ch.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_coord();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, PANEL_COLS_USED - 1));
    endfunction

    task automatic test_pixel_access();
        send_command(ACT_FLUSH, 8'd0, 8'd0, 1'b0, 8'd0);
        send_command(ACT_SET, 8'd0,  8'd0,  1'b1, 8'd0);
        send_command(ACT_SET, 8'd11, 8'd0,  1'b1, 8'hFF);
        send_command(ACT_SET, 8'd0,  8'd11, 1'b1, 8'd0);
        send_command(ACT_SET, 8'd11, 8'd11, 1'b1, 8'hFF);
        send_command(ACT_GET, 8'd0,  8'd0,  1'b0, 8'd0);
        send_command(ACT_GET, 8'd1,  8'd0,  1'b1, 8'd0);
        send_command(ACT_SET, 8'd11, 8'd0,  1'b0, 8'd0);
        send_command(ACT_GET, 8'd11, 8'd0,  1'b0, 8'd0);
        send_command(ACT_GET, 8'd11, 8'd11, 1'b0, 8'd0);
        // out-of-range coordinates: ignored on write, read back as 0
        send_command(ACT_SET, 8'd12,  8'd0,   1'b1, 8'd0);
        send_command(ACT_SET, 8'd0,   8'd12,  1'b1, 8'd0);
        send_command(ACT_SET, 8'hFF,  8'hFF,  1'b1, 8'hFF);
        send_command(ACT_GET, 8'd12,  8'd0,   1'b0, 8'd0);
        send_command(ACT_GET, 8'hFF,  8'hFF,  1'b1, 8'd0);
        // nibble bit reversal shows up in the serialized words
        send_command(ACT_FLUSH, 8'd0, 8'd0, 1'b0, 8'd0);
    endtask

    task automatic test_fill_flush();
        send_command(ACT_FILL,  8'd0,  8'd0, 1'b1, 8'd0);
        send_command(ACT_GET,   8'd12, 8'd3, 1'b0, 8'd0);
        send_command(ACT_FLUSH, 8'hFF, 8'hFF, 1'b1, 8'hFF);
        send_command(ACT_FILL,  8'hFF, 8'hFF, 1'b0, 8'hFF);
    endtask

    task automatic test_brightness_levels();
        send_command(ACT_BRIGHTNESS, 8'd0, 8'd0, 1'b0, 8'd0);
        send_command(ACT_BRIGHTNESS, 8'd0, 8'd0, 1'b0, 8'd15);
        send_command(ACT_BRIGHTNESS, 8'd0, 8'd0, 1'b0, 8'd16);
        send_command(ACT_BRIGHTNESS, 8'd0, 8'd0, 1'b1, 8'hFF);
    endtask

    task automatic test_spare_actions();
        for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
            send_command(3'(a), 8'd5, 8'd5, 1'b1, 8'd9);
    endtask

    // receiver holds off while commands keep coming, so the block backs up
    task automatic test_backpressure();
        idling_on       = 1'b0;
        hold_off_cycles = 150;
        send_command(ACT_FLUSH, 8'd0, 8'd0, 1'b0, 8'd0);
        for (int i = 0; i < 8; i++)
            send_command((i % 2) ? ACT_GET : ACT_SET, pick_coord(), pick_coord(),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        send_command(ACT_BRIGHTNESS, 8'd0, 8'd0, 1'b0, 8'd7);
        idling_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int         r;
        logic [2:0] act;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] level;
        for (int n = 0; n < RANDOM_CMDS; n++) begin
            // a stretch in the middle runs with no idling on either side
            idling_on = !(n >= RANDOM_CMDS / 3 && n < RANDOM_CMDS / 2);
            r     = $urandom_range(0, 99);
            x     = pick_coord();
            y     = pick_coord();
            level = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 20))
                                                : 8'($urandom_range(0, 255));
            if (r < 30)
                act = ACT_SET;
            else if (r < 60)
                act = ACT_GET;
            else if (r < 66)
                act = ACT_FILL;
            else if (r < 74)
                act = ACT_FLUSH;
            else if (r < 88)
                act = ACT_BRIGHTNESS;
            else if (r < 92)
                act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            else begin
                act = 3'($urandom_range(0, 7));
                x   = 8'($urandom_range(0, 255));
                y   = 8'($urandom_range(0, 255));
            end
            send_command(act, x, y, 1'($urandom_range(0, 1)), level);
        end
        idling_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n                = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.action           = ACT_SET;
        in_ch.pos_x            = 8'd0;
        in_ch.pos_y            = 8'd0;
        in_ch.pixel_on         = 1'b0;
        in_ch.brightness_level = 8'd0;
        for (int i = 0; i < STORE_BYTES; i++)
            frame_bytes[i] = 8'h00;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_pixel_access();
        test_fill_flush();
        test_brightness_levels();
        test_spare_actions();
        test_backpressure();
        test_random_traffic();
        drop_valid();

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
